### design/cbds_pkg.sv
`default_nettype none

package cbds_pkg;

    localparam int MAX_CELLS   = 64;
    localparam int MV_W        = 13;
    localparam int IDX_W       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W       = $clog2(MAX_CELLS + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int STORE_DEPTH = 2 ** ADDR_W;
    localparam int PROD_W      = 17;
    localparam int BIN_TOP     = 10;
    localparam int BIN_W       = 4;
    localparam int DUTY_W      = 7;
    localparam int DUTY_STEP   = 10;
    localparam int OUT_IDX_W   = 6;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIMIT     = CFG_IDX_W'(2);

    localparam logic [MV_W-1:0] OVER_LIMIT_RESET = MV_W'(4200);
    localparam logic [MV_W-1:0] FULL_LIMIT_RESET = MV_W'(4175);

    typedef struct packed {
        logic [MV_W-1:0]  min_mv;
        logic [MV_W-1:0]  max_mv;
        logic [CNT_W-1:0] count;
        logic             bank;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [MV_W-1:0]   data;
    } store_wr_t;

    typedef struct packed {
        logic            balance_enable;
        logic [MV_W-1:0] over_limit_mv;
        logic [MV_W-1:0] full_limit_mv;
    } cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_THRESH,
        BK_READ,
        BK_DIFF,
        BK_CMP,
        BK_EMIT,
        BK_OUT
    } back_state_t;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [BIN_W-1:0] bin);
        logic [DUTY_W-1:0] d;
        begin
            d = DUTY_W'(bin) * DUTY_W'(DUTY_STEP);
            return d;
        end
    endfunction

endpackage

`default_nettype wire

### design/cbds_front.sv
`default_nettype none

module cbds_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [cbds_pkg::MV_W-1:0]     cell_voltage_mv,
    input  wire logic                          last_cell,
    input  wire logic                          queue_full,
    output cbds_pkg::store_wr_t                store_wr,
    output logic                               push,
    output cbds_pkg::job_t                     push_job
);

    logic [cbds_pkg::CNT_W-1:0] count_reg, count_next;
    logic [cbds_pkg::MV_W-1:0]  min_reg, min_next;
    logic [cbds_pkg::MV_W-1:0]  max_reg, max_next;
    logic                       bank_reg, bank_next;

    logic                       accept;
    logic                       room;
    logic [cbds_pkg::CNT_W-1:0] cnt_upd;
    logic [cbds_pkg::MV_W-1:0]  min_upd;
    logic [cbds_pkg::MV_W-1:0]  max_upd;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign room     = count_reg < cbds_pkg::CNT_W'(cbds_pkg::MAX_CELLS);

    // cells beyond the store size are neither stored nor tracked
    always_comb
    begin
        cnt_upd = count_reg;
        min_upd = min_reg;
        max_upd = max_reg;
        if (room)
        begin
            cnt_upd = count_reg + cbds_pkg::CNT_W'(1);
            if (cell_voltage_mv < min_reg)
                min_upd = cell_voltage_mv;
            if (cell_voltage_mv > max_reg)
                max_upd = cell_voltage_mv;
        end
    end

    always_comb
    begin
        store_wr.en   = accept && room;
        store_wr.addr = {bank_reg, count_reg[cbds_pkg::IDX_W-1:0]};
        store_wr.data = cell_voltage_mv;

        push            = accept && last_cell;
        push_job.min_mv = min_upd;
        push_job.max_mv = max_upd;
        push_job.count  = cnt_upd;
        push_job.bank   = bank_reg;

        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (last_cell)
            begin
                count_next = '0;
                min_next   = '1;
                max_next   = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = cnt_upd;
                min_next   = min_upd;
                max_next   = max_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

`default_nettype wire

### design/cbds_queue.sv
`default_nettype none

module cbds_queue (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire cbds_pkg::job_t push_job,
    input  wire logic    pop,
    output logic         full,
    output logic         job_valid,
    output cbds_pkg::job_t head
);

    cbds_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign full      = fill_reg == 2'd2;
    assign job_valid = fill_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

### design/cbds_back.sv
`default_nettype none

module cbds_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cbds_pkg::store_wr_t               store_wr,
    input  wire logic                              job_valid,
    input  wire cbds_pkg::job_t                    job,
    input  wire cbds_pkg::cfg_t                    cfg,
    output logic                                   job_done,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [cbds_pkg::OUT_IDX_W-1:0]         cell_index,
    output logic [cbds_pkg::DUTY_W-1:0]            duty_percent,
    output logic                                   over_voltage,
    output logic                                   pack_full,
    output logic                                   last_result
);

    logic [cbds_pkg::MV_W-1:0] store_mem [cbds_pkg::STORE_DEPTH];
    logic [cbds_pkg::MV_W-1:0] rd_data_reg;
    logic                      rd_en;
    logic [cbds_pkg::ADDR_W-1:0] rd_addr;

    cbds_pkg::back_state_t state_reg, state_next;
    logic [cbds_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [cbds_pkg::BIN_W-1:0]  k_reg, k_next;
    logic [cbds_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [cbds_pkg::PROD_W-1:0] thr_reg [cbds_pkg::BIN_TOP];
    logic                        thr_we;
    logic [cbds_pkg::PROD_W-1:0] diff_reg, diff_next;
    logic [cbds_pkg::BIN_TOP-1:0] ge_reg, ge_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_load;
    logic [cbds_pkg::OUT_IDX_W-1:0] cell_index_reg, cell_index_next;
    logic [cbds_pkg::DUTY_W-1:0]   duty_reg, duty_next;
    logic                          over_reg, over_next;
    logic                          full_reg, full_next;
    logic                          last_reg, last_next;

    logic [cbds_pkg::MV_W-1:0] span;
    logic [cbds_pkg::MV_W-1:0] delta;
    logic                      flat;

    assign flat  = job.max_mv <= job.min_mv;
    assign span  = flat ? '0 : job.max_mv - job.min_mv;
    assign delta = (rd_data_reg >= job.min_mv) ? rd_data_reg - job.min_mv : '0;

    assign rd_en   = state_reg == cbds_pkg::BK_READ;
    assign rd_addr = {job.bank, idx_reg[cbds_pkg::IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            store_mem[store_wr.addr] <= store_wr.data;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        thr_we          = 1'b0;
        diff_next       = diff_reg;
        ge_next         = ge_reg;
        out_valid_next  = out_valid_reg;
        out_load        = 1'b0;
        cell_index_next = cell_index_reg;
        duty_next       = duty_reg;
        over_next       = over_reg;
        full_next       = full_reg;
        last_next       = last_reg;
        job_done        = 1'b0;

        case (state_reg)
            cbds_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    idx_next   = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = cbds_pkg::BK_THRESH;
                end
            end
            // bin boundaries k*span, k = 1..10, one add per cycle
            cbds_pkg::BK_THRESH:
            begin
                acc_next = acc_reg + cbds_pkg::PROD_W'(span);
                thr_we   = 1'b1;
                k_next   = k_reg + cbds_pkg::BIN_W'(1);
                if (k_reg == cbds_pkg::BIN_W'(cbds_pkg::BIN_TOP - 1))
                    state_next = cbds_pkg::BK_READ;
            end
            cbds_pkg::BK_READ:
            begin
                state_next = cbds_pkg::BK_DIFF;
            end
            // 11 * (v - min) by shift and add
            cbds_pkg::BK_DIFF:
            begin
                diff_next = (cbds_pkg::PROD_W'(delta) << 3)
                          + (cbds_pkg::PROD_W'(delta) << 1)
                          + cbds_pkg::PROD_W'(delta);
                state_next = cbds_pkg::BK_CMP;
            end
            // thermometer code, saturates at ten so the top cell clamps
            cbds_pkg::BK_CMP:
            begin
                for (int k = 0; k < cbds_pkg::BIN_TOP; k++)
                    ge_next[k] = diff_reg >= thr_reg[k];
                state_next = cbds_pkg::BK_EMIT;
            end
            cbds_pkg::BK_EMIT:
            begin
                out_load        = 1'b1;
                out_valid_next  = 1'b1;
                cell_index_next = cbds_pkg::OUT_IDX_W'(idx_reg);
                if (!cfg.balance_enable || flat)
                    duty_next = '0;
                else
                    duty_next = cbds_pkg::duty_of(cbds_pkg::BIN_W'($countones(ge_reg)));
                over_next  = job.max_mv > cfg.over_limit_mv;
                full_next  = job.min_mv > cfg.full_limit_mv;
                last_next  = cbds_pkg::CNT_W'(idx_reg + cbds_pkg::CNT_W'(1)) == job.count;
                state_next = cbds_pkg::BK_OUT;
            end
            cbds_pkg::BK_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        job_done   = 1'b1;
                        state_next = cbds_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + cbds_pkg::CNT_W'(1);
                        state_next = cbds_pkg::BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = cbds_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbds_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        ge_reg   <= ge_next;
        if (thr_we)
            thr_reg[k_reg] <= acc_next;
        if (out_load)
        begin
            cell_index_reg <= cell_index_next;
            duty_reg       <= duty_next;
            over_reg       <= over_next;
            full_reg       <= full_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_index   = cell_index_reg;
    assign duty_percent = duty_reg;
    assign over_voltage = over_reg;
    assign pack_full    = full_reg;
    assign last_result  = last_reg;

endmodule

`default_nettype wire

### design/cell_balancer_duty_select.sv
// Cell balancer duty selector.
// Input channel (in_valid / in_stall): one cell voltage in mV per transfer,
// cells in index order, last_cell set on the final cell of a pack. Cells are
// taken one per cycle while in_stall is low.
// Output channel (out_valid / out_stall): after the last cell of a pack, one
// result per stored cell in index order, last_result set on the final one.
// With the back end idle, once the last cell transfers the back end picks up
// the pack, runs a pass that builds the bin boundaries from the pack span,
// then takes each cell through the store read, scale, compare and output
// register. Each further result goes through these steps again after the
// previous one transfers, so they do not overlap, and the receiver holding
// out_stall high delays them further.
// Two packs may be held at once: one being emitted from one half of the cell
// store while the next loads into the other half. in_stall rises when both
// halves are taken and falls when the older pack's last result transfers.
// Cells beyond 64 in a pack are dropped; their last_cell mark still counts.
// A stalled result holds its payload until it transfers. The user must write
// configuration (cfg_write_en, cfg_index, cfg_data) between packs; the block
// does not enforce this. After reset: balancing disabled, over limit
// 4200 mV, full limit 4175 mV, no pack pending, out_valid low.
`default_nettype none

module cell_balancer_duty_select (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [12:0]                         cell_voltage_mv,
    input  wire logic                                last_cell,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [5:0]                               cell_index,
    output logic [6:0]                               duty_percent,
    output logic                                     over_voltage,
    output logic                                     pack_full,
    output logic                                     last_result,
    input  wire logic                                cfg_write_en,
    input  wire logic [cbds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [12:0]                         cfg_data
);

    logic                      enable_reg;
    logic [cbds_pkg::MV_W-1:0] over_limit_reg;
    logic [cbds_pkg::MV_W-1:0] full_limit_reg;
    cbds_pkg::cfg_t            cfg;

    cbds_pkg::store_wr_t store_wr;
    logic                push;
    cbds_pkg::job_t      push_job;
    logic                queue_full;
    logic                job_valid;
    cbds_pkg::job_t      head;
    logic                job_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            over_limit_reg <= cbds_pkg::OVER_LIMIT_RESET;
            full_limit_reg <= cbds_pkg::FULL_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                cbds_pkg::CFG_BALANCE_ENABLE: enable_reg     <= cfg_data[0];
                cbds_pkg::CFG_OVER_LIMIT:     over_limit_reg <= cfg_data;
                cbds_pkg::CFG_FULL_LIMIT:     full_limit_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    assign cfg.balance_enable = enable_reg;
    assign cfg.over_limit_mv  = over_limit_reg;
    assign cfg.full_limit_mv  = full_limit_reg;

    cbds_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cell_voltage_mv (cell_voltage_mv),
        .last_cell       (last_cell),
        .queue_full      (queue_full),
        .store_wr        (store_wr),
        .push            (push),
        .push_job        (push_job)
    );

    cbds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (job_done),
        .full      (queue_full),
        .job_valid (job_valid),
        .head      (head)
    );

    cbds_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .store_wr     (store_wr),
        .job_valid    (job_valid),
        .job          (head),
        .cfg          (cfg),
        .job_done     (job_done),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_index   (cell_index),
        .duty_percent (duty_percent),
        .over_voltage (over_voltage),
        .pack_full    (pack_full),
        .last_result  (last_result)
    );

endmodule

`default_nettype wire

### design/cbds_checker.sv
`default_nettype none

module cbds_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] duty_percent
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_percent <= 7'd100)
        else $error("duty above 100");

    a_duty_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent == 7'd0 || duty_percent == 7'd10
            || duty_percent == 7'd20 || duty_percent == 7'd30
            || duty_percent == 7'd40 || duty_percent == 7'd50
            || duty_percent == 7'd60 || duty_percent == 7'd70
            || duty_percent == 7'd80 || duty_percent == 7'd90
            || duty_percent == 7'd100))
        else $error("duty not a multiple of ten");

    // each result is recomputed from the store, so a transfer leaves a gap
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result repeated after transfer");

endmodule

bind cell_balancer_duty_select cbds_checker u_cbds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty_percent (duty_percent)
);

`default_nettype wire
